@@ src/y2r_pkg.sv @@
// Shared types and constants for the 4:2:2 pair to RGB888 converter.
package y2r_pkg;

	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int FRAC_W  = 16;
	localparam int COEF_W  = 18;	// unsigned Q1.16 plus a zero sign bit
	localparam int TERM_W  = 27;	// signed Q.16 products and channel sums

	// Q2.16 coefficients, rounded to the nearest 1/65536
	localparam logic signed [COEF_W-1:0] COEF_R_FROM_B = 18'sd89831;
	localparam logic signed [COEF_W-1:0] COEF_G_FROM_B = 18'sd45744;
	localparam logic signed [COEF_W-1:0] COEF_G_FROM_A = 18'sd22127;
	localparam logic signed [COEF_W-1:0] COEF_B_FROM_A = 18'sd113538;

	// Chroma products shared by both pixel lanes
	typedef struct packed {
		logic signed [TERM_W-1:0] r_from_b;
		logic signed [TERM_W-1:0] g_from_b;
		logic signed [TERM_W-1:0] g_from_a;
		logic signed [TERM_W-1:0] b_from_a;
	} chroma_terms_t;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_t;

endpackage

@@ src/y2r_if.sv @@
// Valid/ready channel interfaces for the word-pair input and the RGB pair output.
interface y2r_pair_if;
	logic                          valid;
	logic                          ready;
	logic [y2r_pkg::WORD_W-1:0]    even_word;
	logic [y2r_pkg::WORD_W-1:0]    odd_word;

	modport source (output valid, output even_word, output odd_word, input ready);
	modport sink (input valid, input even_word, input odd_word, output ready);
endinterface

interface y2r_rgb_if;
	logic                          valid;
	logic                          ready;
	logic [y2r_pkg::BYTE_W-1:0]    red_0;
	logic [y2r_pkg::BYTE_W-1:0]    green_0;
	logic [y2r_pkg::BYTE_W-1:0]    blue_0;
	logic [y2r_pkg::BYTE_W-1:0]    red_1;
	logic [y2r_pkg::BYTE_W-1:0]    green_1;
	logic [y2r_pkg::BYTE_W-1:0]    blue_1;

	modport source (output valid, output red_0, output green_0, output blue_0,
		output red_1, output green_1, output blue_1, input ready);
	modport sink (input valid, input red_0, input green_0, input blue_0,
		input red_1, input green_1, input blue_1, output ready);
endinterface

@@ src/y2r_chroma.sv @@
// Stage 1: chroma offset removal and the four shared coefficient products.
module y2r_chroma (
	input  logic                          clk,
	input  logic                          load,
	input  logic [y2r_pkg::BYTE_W-1:0]    chroma_a,
	input  logic [y2r_pkg::BYTE_W-1:0]    chroma_b,
	output y2r_pkg::chroma_terms_t        terms_s1
);
	import y2r_pkg::*;

	logic signed [BYTE_W-1:0] ca;
	logic signed [BYTE_W-1:0] cb;
	chroma_terms_t            terms_d;

	// chroma - 128 is the byte with its top bit flipped
	assign ca = {~chroma_a[BYTE_W-1], chroma_a[BYTE_W-2:0]};
	assign cb = {~chroma_b[BYTE_W-1], chroma_b[BYTE_W-2:0]};

	always_comb begin
		terms_d.r_from_b = TERM_W'(COEF_R_FROM_B) * TERM_W'(cb);
		terms_d.g_from_b = TERM_W'(COEF_G_FROM_B) * TERM_W'(cb);
		terms_d.g_from_a = TERM_W'(COEF_G_FROM_A) * TERM_W'(ca);
		terms_d.b_from_a = TERM_W'(COEF_B_FROM_A) * TERM_W'(ca);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			terms_s1 <= terms_d;
		end
	end

endmodule

@@ src/y2r_lane.sv @@
// Pixel lane: add the chroma products to luma (green subtracts them), truncate and clamp each channel.
module y2r_lane (
	input  logic [y2r_pkg::BYTE_W-1:0]    luma,
	input  y2r_pkg::chroma_terms_t        terms,
	output y2r_pkg::rgb_t                 pixel
);
	import y2r_pkg::*;

	logic signed [TERM_W-1:0] base;
	logic signed [TERM_W-1:0] sum_r;
	logic signed [TERM_W-1:0] sum_g;
	logic signed [TERM_W-1:0] sum_b;

	// Negative sums truncate to zero or below and clamp to 0
	function automatic logic [BYTE_W-1:0] clamp_q16(input logic signed [TERM_W-1:0] sum);
		logic [BYTE_W-1:0] res;
		if (sum[TERM_W-1]) begin
			res = '0;
		end else if (|sum[TERM_W-2:FRAC_W+BYTE_W]) begin
			res = '1;
		end else begin
			res = sum[FRAC_W+BYTE_W-1:FRAC_W];
		end
		return res;
	endfunction

	assign base  = {{(TERM_W-BYTE_W-FRAC_W){1'b0}}, luma, {FRAC_W{1'b0}}};
	assign sum_r = base + terms.r_from_b;
	assign sum_g = base - terms.g_from_b - terms.g_from_a;
	assign sum_b = base + terms.b_from_a;

	always_comb begin
		pixel.red   = clamp_q16(sum_r);
		pixel.green = clamp_q16(sum_g);
		pixel.blue  = clamp_q16(sum_b);
	end

endmodule

@@ src/y2r_merge.sv @@
// Output stage: join both lanes into one result and hold it until taken.
module y2r_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  take,
	input  y2r_pkg::rgb_t         pixel_0,
	input  y2r_pkg::rgb_t         pixel_1,
	output logic                  valid_q,
	output y2r_pkg::rgb_t         pixel_0_q,
	output y2r_pkg::rgb_t         pixel_1_q
);
	import y2r_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_0_q <= pixel_0;
			pixel_1_q <= pixel_1;
		end
	end

endmodule

@@ src/yuv422_pair_to_rgb.sv @@
// Top level: 4:2:2 word pair to two RGB888 pixels, two lanes sharing chroma.
//
// Usage:
//   pair   - valid/ready sink. Each request carries one 4:2:2 word pair:
//            even_word = {chroma A, luma 0}, odd_word = {chroma B, luma 1}.
//   pixels - valid/ready source. Each request carries two RGB888 pixels
//            that share the pair's chroma (red_0..blue_0 from luma 0,
//            red_1..blue_1 from luma 1), each channel truncated toward
//            zero and clamped to 0..255.
// Path: stage 1 registers the four chroma products and both luma bytes on the
//   accepting edge; both pixel lanes then add luma, clamp, and the merged result
//   lands in the output register, which drives pixels.valid.
// Throughput: one pair per clock while pixels.ready stays high, set by the fully
//   pipelined multiplier stage and the two parallel pixel lanes.
// Stall: while pixels.ready is low the output request holds steady; the
//   stage-1 register keeps absorbing one more pair, after which pair.ready
//   drops. No request is dropped or repeated.
// Reset: arst_n clears both valid flags asynchronously; the data registers are not
//   reset, and pair.ready is already high when reset releases.
module yuv422_pair_to_rgb (
	input  logic          clk,
	input  logic          arst_n,
	y2r_pair_if.sink      pair,
	y2r_rgb_if.source     pixels
);
	import y2r_pkg::*;

	logic             valid_s1;
	logic [BYTE_W-1:0] luma_0_s1;
	logic [BYTE_W-1:0] luma_1_s1;
	chroma_terms_t    terms_s1;
	rgb_t             lane_0;
	rgb_t             lane_1;
	rgb_t             pixel_0_q;
	rgb_t             pixel_1_q;
	logic             out_valid_q;
	logic             out_free;
	logic             advance_s1;
	logic             accept_in;

	// Output register frees when empty or when its request is taken this edge
	assign out_free   = !out_valid_q || pixels.ready;
	assign advance_s1 = valid_s1 && out_free;
	assign pair.ready = !valid_s1 || out_free;
	assign accept_in  = pair.valid && pair.ready;

	// Stage 1 valid: fill on accept, drain on advance, hold otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			luma_0_s1 <= pair.even_word[BYTE_W-1:0];
			luma_1_s1 <= pair.odd_word[BYTE_W-1:0];
		end
	end

	// Shared chroma products, computed once per pair
	y2r_chroma u_chroma (
		.clk      (clk),
		.load     (accept_in),
		.chroma_a (pair.even_word[WORD_W-1:BYTE_W]),
		.chroma_b (pair.odd_word[WORD_W-1:BYTE_W]),
		.terms_s1 (terms_s1)
	);

	// One lane per luma sample
	y2r_lane u_lane_0 (
		.luma  (luma_0_s1),
		.terms (terms_s1),
		.pixel (lane_0)
	);

	y2r_lane u_lane_1 (
		.luma  (luma_1_s1),
		.terms (terms_s1),
		.pixel (lane_1)
	);

	// Merge both lanes into the output request
	y2r_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance_s1),
		.take      (pixels.ready),
		.pixel_0   (lane_0),
		.pixel_1   (lane_1),
		.valid_q   (out_valid_q),
		.pixel_0_q (pixel_0_q),
		.pixel_1_q (pixel_1_q)
	);

	assign pixels.valid   = out_valid_q;
	assign pixels.red_0   = pixel_0_q.red;
	assign pixels.green_0 = pixel_0_q.green;
	assign pixels.blue_0  = pixel_0_q.blue;
	assign pixels.red_1   = pixel_1_q.red;
	assign pixels.green_1 = pixel_1_q.green;
	assign pixels.blue_1  = pixel_1_q.blue;

endmodule

@@ tb/yuv422_pair_to_rgb_tb.sv @@
`timescale 1ns / 1ps
// Testbench for yuv422_pair_to_rgb: random and directed word pairs, with stalls on both sides.
module yuv422_pair_to_rgb_tb;
	import y2r_pkg::*;

	// Q2.16 coefficients, nearest step of 1/65536
	localparam longint K_RED_FROM_B   = 89831;
	localparam longint K_GREEN_FROM_B = 45744;
	localparam longint K_GREEN_FROM_A = 22127;
	localparam longint K_BLUE_FROM_A  = 113538;
	localparam longint CHROMA_MID     = 128;
	localparam int     Q_BITS         = 16;

	localparam int RANDOM_PAIRS = 1900;
	localparam int CHUNKS       = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// Holds the expected pixel pairs in order and checks each one that leaves the block.
	class rgb_pair_scoreboard;
		typedef struct {
			rgb_t px0;
			rgb_t px1;
		} rgb_pair_t;

		rgb_pair_t expected_pixels[$];
		int        errors = 0;

		// Truncate a signed Q.16 sum toward zero, then clamp to a byte.
		function automatic logic [7:0] q16_to_byte(longint sum);
			longint whole;
			whole = (sum >= 0) ? (sum >>> Q_BITS) : -((-sum) >>> Q_BITS);
			if (whole < 0)
				return 8'd0;
			if (whole > 255)
				return 8'd255;
			return whole[7:0];
		endfunction

		function automatic rgb_t pixel_from_luma(logic [7:0] luma, longint ca, longint cb);
			longint base;
			rgb_t   px;
			base     = longint'(luma) << Q_BITS;
			px.red   = q16_to_byte(base + K_RED_FROM_B * cb);
			px.green = q16_to_byte(base - K_GREEN_FROM_B * cb - K_GREEN_FROM_A * ca);
			px.blue  = q16_to_byte(base + K_BLUE_FROM_A * ca);
			return px;
		endfunction

		function void note_pair(logic [WORD_W-1:0] even_word, logic [WORD_W-1:0] odd_word);
			longint    ca;
			longint    cb;
			rgb_pair_t exp_pair;
			ca           = longint'(even_word[15:8]) - CHROMA_MID;
			cb           = longint'(odd_word[15:8]) - CHROMA_MID;
			exp_pair.px0 = pixel_from_luma(even_word[7:0], ca, cb);
			exp_pair.px1 = pixel_from_luma(odd_word[7:0], ca, cb);
			expected_pixels.push_back(exp_pair);
		endfunction

		function void match_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
			if (exp_val !== act_val) begin
				$error("%s: expected %0d, got %0d", name, exp_val, act_val);
				errors++;
			end
		endfunction

		function void check_pixels(rgb_t px0, rgb_t px1);
			rgb_pair_t exp_pair;
			if (expected_pixels.size() == 0) begin
				$error("pixel pair arrived with nothing expected");
				errors++;
				return;
			end
			exp_pair = expected_pixels.pop_front();
			match_field("red_0", exp_pair.px0.red, px0.red);
			match_field("green_0", exp_pair.px0.green, px0.green);
			match_field("blue_0", exp_pair.px0.blue, px0.blue);
			match_field("red_1", exp_pair.px1.red, px1.red);
			match_field("green_1", exp_pair.px1.green, px1.green);
			match_field("blue_1", exp_pair.px1.blue, px1.blue);
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;
	bit   tx_gaps = 1'b0;	// sender drops valid in short bursts
	bit   rx_gaps = 1'b0;	// receiver drops ready in short bursts

	rgb_pair_scoreboard pix_board = new;

	y2r_pair_if pair_ch ();
	y2r_rgb_if  pix_ch ();

	yuv422_pair_to_rgb dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch.sink),
		.pixels (pix_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run; a hung handshake ends up here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Sample both handshakes at the edge. A pair is noted before any output of the same
	// edge is checked; a pair passes the stage-1 and output registers first, so they never belong together.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pair_ch.valid && pair_ch.ready)
				pix_board.note_pair(pair_ch.even_word, pair_ch.odd_word);
			if (pix_ch.valid && pix_ch.ready)
				pix_board.check_pixels(
					'{red: pix_ch.red_0, green: pix_ch.green_0, blue: pix_ch.blue_0},
					'{red: pix_ch.red_1, green: pix_ch.green_1, blue: pix_ch.blue_1});
		end
	end

	// Receiver: hold ready high, drop it for a random stretch now and then while
	// stalls are enabled.
	initial begin
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_gaps && $urandom_range(0, 4) == 0) begin
				pix_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			pix_ch.ready <= 1'b1;
		end
	end

	// Present one request and hold it until the block takes it. Returns on the
	// accepting edge with valid still high, so a back-to-back request follows
	// without a bubble.
	task automatic send_pair(logic [WORD_W-1:0] even_word, logic [WORD_W-1:0] odd_word);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			pair_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pair_ch.valid     <= 1'b1;
		pair_ch.even_word <= even_word;
		pair_ch.odd_word  <= odd_word;
		do
			@(posedge clk);
		while (!pair_ch.ready);
	endtask

	// Favor the bytes that drive the clamps: full-scale chroma and luma,
	// chroma close to the midpoint, and plain random values.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(CHROMA_MID - 8, CHROMA_MID + 8));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_random_pair();
		if ($urandom_range(0, 1) == 0)
			send_pair(16'($urandom), 16'($urandom));
		else
			send_pair({pick_byte(), pick_byte()}, {pick_byte(), pick_byte()});
	endtask

	initial begin
		pair_ch.valid     <= 1'b0;
		pair_ch.even_word <= '0;
		pair_ch.odd_word  <= '0;
		arst_n            <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes of every byte, neutral chroma, and chroma that
		// pushes each channel past either clamp.
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		send_pair(16'h0000, 16'h0000);
		send_pair(16'hFFFF, 16'hFFFF);
		send_pair(16'h8000, 16'h80FF);
		send_pair(16'h80FF, 16'h8000);
		send_pair(16'h0000, 16'hFFFF);
		send_pair(16'hFFFF, 16'h0000);
		send_pair(16'h00FF, 16'h00FF);	// green above 255, red and blue low
		send_pair(16'hFF00, 16'hFF00);	// red and blue high from zero luma, green below 0
		send_pair(16'h0080, 16'hFF80);
		send_pair(16'hFF80, 16'h0080);
		send_pair(16'hAAAA, 16'h5555);
		send_pair(16'h5555, 16'hAAAA);
		send_pair(16'h7F01, 16'h81FE);
		send_pair(16'h8110, 16'h7FEF);
		send_pair(16'h0110, 16'hFEEB);
		send_pair(16'hFE10, 16'h01EB);

		// Random: rotate stall patterns, including stretches with none,
		// and finish without any idling.
		for (int chunk = 0; chunk < CHUNKS; chunk++) begin
			case (chunk)
				0: begin tx_gaps = 1'b1; rx_gaps = 1'b1; end
				1: begin tx_gaps = 1'b0; rx_gaps = 1'b0; end
				2: begin tx_gaps = 1'b0; rx_gaps = 1'b1; end
				3: begin tx_gaps = 1'b1; rx_gaps = 1'b0; end
				default: begin tx_gaps = 1'b0; rx_gaps = 1'b0; end
			endcase
			repeat (RANDOM_PAIRS / CHUNKS) send_random_pair();
		end
		pair_ch.valid <= 1'b0;

		// Drain, then give the pipeline time to show any stray output.
		while (pix_board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pix_board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ files.f @@
src/y2r_pkg.sv
src/y2r_if.sv
src/y2r_chroma.sv
src/y2r_lane.sv
src/y2r_merge.sv
src/yuv422_pair_to_rgb.sv
tb/yuv422_pair_to_rgb_tb.sv
